### rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Framebuffer draw engine package
// Shared geometry constants, command codes and the 5x7 glyph table.
// ---------------------------------------------------------------------------
package mfb_pkg;

  localparam int DispW      = 128;
  localparam int DispH      = 64;
  localparam int PageCount  = (DispH + 7) / 8;
  localparam int StoreBytes = DispW * PageCount;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int GlyphFirst = 32;
  localparam int GlyphLast  = 127;
  localparam int GlyphCols  = 5;
  localparam int GlyphRows  = 7;

  typedef enum logic [2:0] {
    REQ_PIXEL = 3'd0,
    REQ_RECT  = 3'd1,
    REQ_FILL  = 3'd2,
    REQ_CHAR  = 3'd3,
    REQ_BAR   = 3'd4,
    REQ_CLEAR = 3'd5,
    REQ_READ  = 3'd6,
    REQ_NOP   = 3'd7
  } req_t;

  // One column byte of a glyph; idx is the code already mapped to 0..95 (code - 32).
  function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] g;
    begin
      unique case (idx)
        7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000;
        7'd2:  g = 40'h0007000700; 7'd3:  g = 40'h147F147F14;
        7'd4:  g = 40'h242A7F2A12; 7'd5:  g = 40'h2313086462;
        7'd6:  g = 40'h3649552250; 7'd7:  g = 40'h0005030000;
        7'd8:  g = 40'h001C224100; 7'd9:  g = 40'h0041221C00;
        7'd10: g = 40'h082A1C2A08; 7'd11: g = 40'h08083E0808;
        7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808;
        7'd14: g = 40'h0060600000; 7'd15: g = 40'h2010080402;
        7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
        7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31;
        7'd20: g = 40'h1814127F10; 7'd21: g = 40'h2745454539;
        7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
        7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E;
        7'd26: g = 40'h0036360000; 7'd27: g = 40'h0056360000;
        7'd28: g = 40'h0008142241; 7'd29: g = 40'h1414141414;
        7'd30: g = 40'h4122140800; 7'd31: g = 40'h0201510906;
        7'd32: g = 40'h324979413E; 7'd33: g = 40'h7E1111117E;
        7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
        7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941;
        7'd38: g = 40'h7F09090101; 7'd39: g = 40'h3E4141497A;
        7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
        7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241;
        7'd44: g = 40'h7F40404040; 7'd45: g = 40'h7F0204027F;
        7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
        7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E;
        7'd50: g = 40'h7F09192946; 7'd51: g = 40'h4649494931;
        7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
        7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h7F2018207F;
        7'd56: g = 40'h6314081463; 7'd57: g = 40'h0304780403;
        7'd58: g = 40'h6151494543; 7'd59: g = 40'h00007F4141;
        7'd60: g = 40'h0204081020; 7'd61: g = 40'h41417F0000;
        7'd62: g = 40'h0402010204; 7'd63: g = 40'h4040404040;
        7'd64: g = 40'h0001020400; 7'd65: g = 40'h2054545478;
        7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420;
        7'd68: g = 40'h384444487F; 7'd69: g = 40'h3854545418;
        7'd70: g = 40'h087E090102; 7'd71: g = 40'h085454543C;
        7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000;
        7'd74: g = 40'h2040443D00; 7'd75: g = 40'h007F102844;
        7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04180478;
        7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438;
        7'd80: g = 40'h7C14141408; 7'd81: g = 40'h081414187C;
        7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
        7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C;
        7'd86: g = 40'h1C2040201C; 7'd87: g = 40'h3C4030403C;
        7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
        7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100;
        7'd92: g = 40'h00007F0000; 7'd93: g = 40'h0041360800;
        7'd94: g = 40'h08082A1C08; 7'd95: g = 40'h081C2A0808;
        default: g = 40'h0;
      endcase
      unique case (col)
        3'd0: glyph_col = g[39:32];
        3'd1: glyph_col = g[31:24];
        3'd2: glyph_col = g[23:16];
        3'd3: glyph_col = g[15:8];
        default: glyph_col = g[7:0];
      endcase
    end
  endfunction

endpackage

### rtl/mfb_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module mfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/mono_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Monochrome framebuffer draw engine
// Draws pixels, rectangles, fills, bars and 5x7 characters into a page-mode store;
// also clears the store and reads single bytes back.
// An item is taken when start is high and busy is low. busy stays high while
// the item is worked on and drops in the cycle in which done strobes the
// item's single result; a new item may be taken at the edge that ends that
// cycle. The store is a single-port RAM of 1024 bytes with a registered read,
// so each drawn column byte goes through address, read data and write back in
// turn. A drawing item is split into rectangles: one for a pixel, a fill or a
// character, four lines for an outline, and four lines plus the inner fill
// for a progress bar. Each rectangle passes a setup state, then one step per
// page it spans and the address, read and write steps for each byte; a
// rectangle that is empty or wholly off the display ends in its setup state.
// The item closes with a last setup state and a done state, and a bar first
// passes a state for its divide by 100. A clear zeroes the store one byte per
// cycle. The work of an item is bounded by its clipped area in bytes. After
// reset the block is busy while it zeroes the store. The receiver cannot stall
// the result: it must take done when it appears.
// ---------------------------------------------------------------------------
module mono_framebuffer_draw_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic [7:0] box_width,
  input  logic [7:0] box_height,
  input  logic [7:0] char_code,
  input  logic       pixel_on,
  input  logic [7:0] percent,
  input  logic [9:0] byte_index,
  output logic       done,
  output logic [7:0] read_data,
  output logic       read_valid
);
  import mfb_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_NEXT, S_SETUP, S_RD, S_WAIT, S_WR, S_RDOUT, S_DONE
  } state_t;

  state_t state;
  req_t   req;
  // Rectangle list: outline as four, bar adds a fifth; char, pixel and fill one.
  logic [2:0] part;
  logic [2:0] nparts;
  logic signed [10:0] bx, by;     // current rectangle origin
  logic signed [10:0] bx1, by1;   // exclusive end
  logic signed [10:0] cx;         // current column
  logic [3:0]  pg;                // current page (0..PageCount-1, plus 1 spare)
  logic signed [10:0] rx, ry;
  logic [8:0]  rw, rh;
  logic signed [10:0] rxe, rye;   // exclusive end of the current rectangle
  logic        on;
  logic [6:0]  gidx;
  logic [9:0]  sweep;
  logic [15:0] prod;
  logic [7:0]  fillw;
  logic [9:0]  bidx;
  logic signed [9:0] pos_x_r, pos_y_r;
  logic [7:0] w_r, h_r;
  logic done_pend;

  // Glyph column is counted from the unclipped left edge.
  // (bx is clipped, so character columns use origin_x.)
  logic signed [10:0] origin_x;

  logic             we;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata, rdata;

  mfb_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Current rectangle of the list.
  always_comb begin
    rx = 11'(pos_x_r); ry = 11'(pos_y_r); rw = 9'(w_r); rh = 9'(h_r);
    priority if (req == REQ_CHAR) begin
      rw = 9'(GlyphCols); rh = 9'(GlyphRows);
    end else if (req == REQ_PIXEL) begin
      rw = 9'd1; rh = 9'd1;
    end else if (req == REQ_FILL) begin
    end else begin
      unique case (part)
        3'd0: rh = 9'd1;
        3'd1: begin ry = 11'(pos_y_r) + 11'(h_r) - 11'sd1; rh = 9'd1; end
        3'd2: rw = 9'd1;
        3'd3: begin rx = 11'(pos_x_r) + 11'(w_r) - 11'sd1; rw = 9'd1; end
        default: begin
          rx = 11'(pos_x_r) + 11'sd1; ry = 11'(pos_y_r) + 11'sd1;
          rw = 9'(fillw); rh = (h_r > 8'd2) ? 9'(h_r - 8'd2) : 9'd0;
        end
      endcase
    end
  end

  assign rxe = rx + $signed({2'b00, rw});
  assign rye = ry + $signed({2'b00, rh});

  // Row mask of the current page within [by, by1).
  logic [7:0] rmask;
  logic signed [10:0] pbase;
  always_comb begin
    pbase = 11'($signed({1'b0, pg, 3'b000}));
    for (int i = 0; i < 8; i++) begin
      rmask[i] = (pbase + 11'(i) >= by) && (pbase + 11'(i) < by1);
    end
  end

  logic [2:0] gcol;
  logic [7:0] gbits, gshift;
  logic signed [10:0] goff;
  always_comb begin
    gcol  = 3'(cx - origin_x);
    gbits = on ? glyph_col(gidx, gcol) : 8'h00;
    goff  = by - pbase;
    if (goff >= 0) gshift = gbits << goff[2:0];
    else           gshift = gbits >> 3'(-goff);
  end

  logic [7:0] newb;
  always_comb begin
    if (req == REQ_CHAR) newb = (rdata & ~rmask) | (gshift & rmask);
    else if (on)         newb = rdata | rmask;
    else                 newb = rdata & ~rmask;
  end

  logic [AddrW-1:0] caddr;
  assign caddr = AddrW'({pg[2:0], cx[6:0]});

  always_comb begin
    we = 1'b0; addr = caddr; wdata = newb;
    unique case (state)
      S_CLEAR: begin we = 1'b1; addr = sweep; wdata = 8'h00; end
      S_WR:    we = 1'b1;
      S_RD:    addr = bidx;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  logic [7:0] pct_sat;
  assign pct_sat = (percent > 8'd100) ? 8'd100 : percent;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR; sweep <= '0; read_valid <= 1'b0; read_data <= '0;
      done_pend <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 10'd1;
          if (sweep == 10'(StoreBytes - 1)) state <= done_pend ? S_DONE : S_IDLE;
        end
        S_IDLE: if (start) begin
          req <= req_t'(req_type);
          pos_x_r <= pos_x; pos_y_r <= pos_y; w_r <= box_width; h_r <= box_height;
          on <= pixel_on; bidx <= byte_index; part <= '0;
          gidx <= (char_code < 8'(GlyphFirst) || char_code > 8'(GlyphLast))
                    ? 7'd31 : 7'(char_code - 8'(GlyphFirst));
          prod <= (box_width >= 8'd2) ? 16'(box_width - 8'd2) * 16'(pct_sat) : 16'd0;
          read_valid <= 1'b0; read_data <= '0;
          unique case (req_t'(req_type))
            REQ_CLEAR: begin state <= S_CLEAR; sweep <= '0; done_pend <= 1'b1; end
            REQ_READ:  state <= S_RD;
            REQ_NOP:   state <= S_DONE;
            REQ_PIXEL, REQ_CHAR, REQ_FILL: begin nparts <= 3'd1; state <= S_SETUP; end
            REQ_RECT:  begin nparts <= 3'd4; state <= S_SETUP; end
            default:   begin nparts <= 3'd5; state <= S_DIV; end
          endcase
        end
        S_DIV: begin
          // Divide by 100 as a multiply by 5243 / 2^19, exact for every
          // product up to 253 * 100.
          fillw <= 8'((32'(prod) * 32'd5243) >> 19);
          state <= S_SETUP;
        end
        S_SETUP: begin
          if (part == nparts) state <= S_DONE;
          else begin
            bx  <= (rx < 0) ? 11'sd0 : rx;
            by  <= ry;
            bx1 <= (rxe > 11'(DispW)) ? 11'(DispW) : rxe;
            by1 <= (rye > 11'(DispH)) ? 11'(DispH) : rye;
            cx  <= (rx < 0) ? 11'sd0 : rx;
            pg  <= (ry < 0) ? 4'd0 : 4'(ry >>> 3);
            if (rw == 0 || rh == 0 || rx >= 11'(DispW) || ry >= 11'(DispH) ||
                rxe <= 11'sd0 || rye <= 11'sd0) begin
              part <= part + 3'd1;
            end else state <= S_NEXT;
            origin_x <= rx;
          end
        end
        S_NEXT: begin
          if (cx >= bx1) begin
            cx <= bx;
            if (11'($signed({1'b0, pg, 3'b000})) + 11'sd8 >= by1) begin
              part <= part + 3'd1; state <= S_SETUP;
            end else pg <= pg + 4'd1;
          end else state <= S_WAIT;
        end
        S_WAIT: state <= S_WR;
        S_WR: begin cx <= cx + 11'sd1; state <= S_NEXT; end
        S_RD: state <= S_RDOUT;
        S_RDOUT: begin read_valid <= 1'b1; read_data <= rdata; state <= S_DONE; end
        default: begin done <= 1'b1; done_pend <= 1'b0; state <= S_IDLE; end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_rv_done: assert property (@(posedge clk) disable iff (rst) read_valid && done |-> req == REQ_READ)
    else $error("read_valid on non-read");
  a_we_busy: assert property (@(posedge clk) disable iff (rst) we |-> busy)
    else $error("write while idle");
endmodule
